>>> rtl/trp_pkg.sv
// shared types, constants and register codes for the three-axis rate pid
package trp_pkg;

  // axis count limits and default
  localparam int AXIS_MAX     = 3;
  localparam int AXIS_DEFAULT = 3;
  localparam int AXIS_IW      = 2;

  // configuration register codes and widths
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 48;
  localparam logic [CFG_IW-1:0] CFG_ROLL_GAINS  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_PITCH_GAINS = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_YAW_GAINS   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_OUT_LIMIT   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_INT_LIMIT   = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_DTERM_ALPHA = 3'd5;

  // register reset values
  localparam logic [47:0] GAINS_RP_RESET = 48'd2113217889829;
  localparam logic [47:0] GAINS_Y_RESET  = 48'd3517631889408;
  localparam logic [14:0] OUT_LIMIT_RESET = 15'd11469;
  localparam logic [14:0] INT_LIMIT_RESET = 15'd6554;
  localparam logic [15:0] ALPHA_RESET     = 16'd9830;

  // datapath widths
  localparam int MUL_AW  = 35;
  localparam int MUL_BW  = 22;
  localparam int PROD_W  = MUL_AW + MUL_BW;
  localparam int DIV_NW  = 50;
  localparam int DIV_DW  = 27;

  // arithmetic constants
  localparam logic [MUL_BW-1:0] USEC_PER_SEC = 22'd1000000;
  localparam logic [DIV_DW-1:0] INTEG_DIV    = 27'd128000000;
  localparam logic [DIV_NW-1:0] INTEG_HALF   = 50'd64000000;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_DMUL, ST_DDIV_GO, ST_DDIV_WAIT, ST_FMUL, ST_FUPD,
    ST_PMUL, ST_KDMUL, ST_DTERM, ST_IMUL_E, ST_IMUL_T, ST_IDIV_GO, ST_IDIV_WAIT,
    ST_SUM, ST_DONE
  } state_t;

  // datapath operations
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CLEAR, OP_DMUL, OP_DDIV_GO, OP_DDIV_WAIT, OP_FMUL,
    OP_FUPD, OP_PMUL, OP_KDMUL, OP_DTERM, OP_IMUL_E, OP_IMUL_T, OP_IDIV_GO,
    OP_IDIV_WAIT, OP_SUM, OP_OUT
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [AXIS_IW-1:0] axis;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic clear;
    logic dt_zero;
    logic integ;
  } dp_status_t;

  typedef struct packed {
    logic signed [15:0] setpoint_roll;
    logic signed [15:0] setpoint_pitch;
    logic signed [15:0] setpoint_yaw;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic        [15:0] dt_us;
    logic               integrate;
    logic               clear;
  } in_beat_t;

endpackage

>>> rtl/trp_in_if.sv
// input channel: one sample beat of setpoints, gyro rates and flags
interface trp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] setpoint_roll;
  logic signed [15:0] setpoint_pitch;
  logic signed [15:0] setpoint_yaw;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic        [15:0] dt_us;
  logic               integrate;
  logic               clear;

  modport source (output valid, setpoint_roll, setpoint_pitch, setpoint_yaw,
                  gyro_x, gyro_y, gyro_z, dt_us, integrate, clear, input ready);
  modport sink   (input valid, setpoint_roll, setpoint_pitch, setpoint_yaw,
                  gyro_x, gyro_y, gyro_z, dt_us, integrate, clear, output ready);
endinterface

>>> rtl/trp_out_if.sv
// output channel: one beat of three axis commands
interface trp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cmd_roll;
  logic signed [15:0] cmd_pitch;
  logic signed [15:0] cmd_yaw;

  modport source (output valid, cmd_roll, cmd_pitch, cmd_yaw, input ready);
  modport sink   (input valid, cmd_roll, cmd_pitch, cmd_yaw, output ready);
endinterface

>>> rtl/three_axis_rate_pid.sv
// three-axis rate pid, top level
// processes one sample at a time; a clear or a zero time step skips the per-axis steps, and
// the integrator steps run only with integrate set
// each axis uses the shared 2-bit-per-cycle divider for its derivative and integrator
// reset (rst, synchronous) restores the register defaults and zeroes axis state
// a finished beat waits in the output register while the next sample is taken
module three_axis_rate_pid #(
  parameter int AXIS_COUNT = trp_pkg::AXIS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  trp_in_if.sink                     in_ch,
  trp_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [trp_pkg::CFG_IW-1:0] cfg_idx,
  input  logic [trp_pkg::CFG_DW-1:0] cfg_wdata
);
  trp_pkg::in_beat_t   in_beat;
  trp_pkg::dp_cmd_t    ctrl_cmd;
  trp_pkg::dp_status_t dp_status;

  // input beat
  assign in_beat.setpoint_roll  = in_ch.setpoint_roll;
  assign in_beat.setpoint_pitch = in_ch.setpoint_pitch;
  assign in_beat.setpoint_yaw   = in_ch.setpoint_yaw;
  assign in_beat.gyro_x         = in_ch.gyro_x;
  assign in_beat.gyro_y         = in_ch.gyro_y;
  assign in_beat.gyro_z         = in_ch.gyro_z;
  assign in_beat.dt_us          = in_ch.dt_us;
  assign in_beat.integrate      = in_ch.integrate;
  assign in_beat.clear          = in_ch.clear;

  trp_ctrl #(.AXIS_COUNT(AXIS_COUNT)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (dp_status),
    .cmd       (ctrl_cmd)
  );

  trp_datapath #(.AXIS_COUNT(AXIS_COUNT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_beat   (in_beat),
    .cmd       (ctrl_cmd),
    .status    (dp_status),
    .res_roll  (out_ch.cmd_roll),
    .res_pitch (out_ch.cmd_pitch),
    .res_yaw   (out_ch.cmd_yaw)
  );

  // one sample in flight at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while a sample is in flight");

  // divider finishes only while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    dp_status.div_done |-> (ctrl_cmd.op == trp_pkg::OP_DDIV_WAIT ||
                            ctrl_cmd.op == trp_pkg::OP_IDIV_WAIT))
    else $error("divider result arrived outside a wait step");

  // output beat appears only after a result load
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(ctrl_cmd.op == trp_pkg::OP_OUT))
    else $error("output valid without a result load");
endmodule

>>> rtl/trp_div.sv
// unsigned restoring divider, two quotient bits per cycle
module trp_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [trp_pkg::DIV_NW-1:0] dividend,
  input  logic [trp_pkg::DIV_DW-1:0] divisor,
  output logic                       done,
  output logic [trp_pkg::DIV_NW-1:0] quotient
);
  localparam int NW    = trp_pkg::DIV_NW;
  localparam int DW    = trp_pkg::DIV_DW;
  localparam int STEPS = NW / 2;
  localparam int CW    = $clog2(STEPS);

  logic [NW-1:0] quo_sh;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;

  logic [DW:0]   r1, r2;
  logic          b1, b2;
  logic [DW-1:0] rem1;

  // two compare-subtract steps
  always_comb begin
    r1 = {rem, quo_sh[NW-1]};
    b1 = (r1 >= {1'b0, dvs});
    if (b1) begin
      r1 = r1 - {1'b0, dvs};
    end
    rem1 = r1[DW-1:0];
    r2 = {rem1, quo_sh[NW-2]};
    b2 = (r2 >= {1'b0, dvs});
    if (b2) begin
      r2 = r2 - {1'b0, dvs};
    end
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quo_sh <= dividend;
      rem    <= '0;
      dvs    <= divisor;
    end else if (busy) begin
      quo_sh <= {quo_sh[NW-3:0], b1, b2};
      rem    <= r2[DW-1:0];
    end
  end

  assign quotient = quo_sh;
endmodule

>>> rtl/trp_datapath.sv
// per-axis pid datapath: registers, state, shared multiplier and divider
module trp_datapath #(
  parameter int AXIS_COUNT = trp_pkg::AXIS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [trp_pkg::CFG_IW-1:0] cfg_idx,
  input  logic [trp_pkg::CFG_DW-1:0] cfg_wdata,
  input  trp_pkg::in_beat_t          in_beat,
  input  trp_pkg::dp_cmd_t           cmd,
  output trp_pkg::dp_status_t        status,
  output logic signed [15:0]         res_roll,
  output logic signed [15:0]         res_pitch,
  output logic signed [15:0]         res_yaw
);
  localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam int PW = trp_pkg::PROD_W;
  localparam int NW = trp_pkg::DIV_NW;
  localparam int DW = trp_pkg::DIV_DW;

  // configuration registers
  logic [47:0] gains [0:trp_pkg::AXIS_MAX-1];
  logic [14:0] olim;
  logic [14:0] ilim;
  logic [15:0] alpha;

  // latched sample
  logic signed [15:0] sp_q [0:trp_pkg::AXIS_MAX-1];
  logic signed [15:0] gy_q [0:trp_pkg::AXIS_MAX-1];
  logic        [15:0] dt_q;
  logic               integ_q;
  logic               clear_q;

  // axis state
  logic signed [31:0] integ_st [0:AXIS_COUNT-1];
  logic signed [15:0] prev_st  [0:AXIS_COUNT-1];
  logic signed [31:0] filt_st  [0:AXIS_COUNT-1];

  // working registers
  logic signed [PW-1:0] prod;
  logic                 div_neg;
  logic signed [31:0]   d_reg;
  logic signed [29:0]   p_reg;
  logic signed [34:0]   dterm_reg;
  logic signed [15:0]   cmd_w [0:trp_pkg::AXIS_MAX-1];

  logic [AW-1:0]               ax;
  logic [trp_pkg::AXIS_IW-1:0] axg;
  logic signed [16:0]          err;
  logic signed [16:0]          delta;
  logic [15:0]                 kp, ki, kd;
  logic signed [trp_pkg::MUL_AW-1:0] mul_a;
  logic signed [trp_pkg::MUL_BW-1:0] mul_b;
  logic signed [PW-1:0]        prod_next;
  logic [PW-1:0]               prod_mag;
  logic                        div_start;
  logic [NW-1:0]               div_n;
  logic [DW-1:0]               div_d;
  logic                        div_done;
  logic [NW-1:0]               quo;
  logic signed [31:0]          d_sat;
  logic signed [PW-1:0]        f_step;
  logic signed [PW:0]          f_sum;
  logic signed [31:0]          f_new;
  logic signed [PW-1:0]        p_rnd, p_shr;
  logic signed [PW-1:0]        dt_rnd, dt_shr;
  logic signed [33:0]          q_val, i_sum, i_lo, i_hi;
  logic signed [31:0]          i_new;
  logic signed [36:0]          total, o_lo, o_hi;
  logic signed [15:0]          cmd_sat;

  assign ax  = cmd.axis[AW-1:0];
  assign axg = cmd.axis;

  // operand selection
  always_comb begin
    err   = 17'(sp_q[axg]) - 17'(gy_q[axg]);
    delta = 17'(gy_q[axg]) - 17'(prev_st[ax]);
    kp    = gains[axg][47:32];
    ki    = gains[axg][31:16];
    kd    = gains[axg][15:0];
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      trp_pkg::OP_DMUL: begin
        mul_a = 35'(delta);
        mul_b = $signed(trp_pkg::USEC_PER_SEC);
      end
      trp_pkg::OP_FMUL: begin
        mul_a = 35'(d_reg) - 35'(filt_st[ax]);
        mul_b = $signed({6'd0, alpha});
      end
      trp_pkg::OP_PMUL: begin
        mul_a = 35'(err);
        mul_b = $signed({6'd0, kp});
      end
      trp_pkg::OP_KDMUL: begin
        mul_a = 35'(filt_st[ax]);
        mul_b = $signed({6'd0, kd});
      end
      trp_pkg::OP_IMUL_E: begin
        mul_a = 35'(err);
        mul_b = $signed({6'd0, ki});
      end
      trp_pkg::OP_IMUL_T: begin
        mul_a = prod[34:0];
        mul_b = $signed({6'd0, dt_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_next = PW'(mul_a) * PW'(mul_b);
  end

  // divider operands
  always_comb begin
    prod_mag  = prod[PW-1] ? PW'(-prod) : PW'(prod);
    div_start = (cmd.op == trp_pkg::OP_DDIV_GO) || (cmd.op == trp_pkg::OP_IDIV_GO);
    if (cmd.op == trp_pkg::OP_DDIV_GO) begin
      div_n = prod_mag[NW-1:0];
      div_d = {{(DW-16){1'b0}}, dt_q};
    end else begin
      div_n = prod_mag[NW-1:0] + trp_pkg::INTEG_HALF;
      div_d = trp_pkg::INTEG_DIV;
    end
  end

  trp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (quo)
  );

  // derivative saturation, filter, rounding and clamps
  always_comb begin
    if (!div_neg) begin
      d_sat = (quo > NW'(32'h7fffffff)) ? 32'sh7fffffff : $signed(quo[31:0]);
    end else begin
      d_sat = (quo > NW'(33'h080000000)) ? 32'sh80000000 : $signed(-quo[31:0]);
    end
    f_step = prod >>> 16;
    f_sum  = (PW+1)'(filt_st[ax]) + (PW+1)'(f_step);
    if (f_sum > (PW+1)'(32'sh7fffffff)) begin
      f_new = 32'sh7fffffff;
    end else if (f_sum < (PW+1)'(32'sh80000000)) begin
      f_new = 32'sh80000000;
    end else begin
      f_new = f_sum[31:0];
    end
    p_rnd  = prod + PW'(64);
    p_shr  = p_rnd >>> 7;
    dt_rnd = prod + PW'(16384);
    dt_shr = dt_rnd >>> 15;
    q_val  = $signed({10'd0, quo[23:0]});
    i_sum  = 34'(integ_st[ax]) + (div_neg ? -q_val : q_val);
    i_hi   = $signed({19'd0, ilim});
    i_lo   = -i_hi;
    if (i_sum > i_hi) begin
      i_new = i_hi[31:0];
    end else if (i_sum < i_lo) begin
      i_new = i_lo[31:0];
    end else begin
      i_new = i_sum[31:0];
    end
    total = 37'(p_reg) + 37'(integ_st[ax]) - 37'(dterm_reg);
    o_hi  = $signed({22'd0, olim});
    o_lo  = -o_hi;
    if (total > o_hi) begin
      cmd_sat = o_hi[15:0];
    end else if (total < o_lo) begin
      cmd_sat = o_lo[15:0];
    end else begin
      cmd_sat = total[15:0];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gains[0] <= trp_pkg::GAINS_RP_RESET;
      gains[1] <= trp_pkg::GAINS_RP_RESET;
      gains[2] <= trp_pkg::GAINS_Y_RESET;
      olim     <= trp_pkg::OUT_LIMIT_RESET;
      ilim     <= trp_pkg::INT_LIMIT_RESET;
      alpha    <= trp_pkg::ALPHA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        trp_pkg::CFG_ROLL_GAINS:  gains[0] <= cfg_wdata;
        trp_pkg::CFG_PITCH_GAINS: gains[1] <= cfg_wdata;
        trp_pkg::CFG_YAW_GAINS:   gains[2] <= cfg_wdata;
        trp_pkg::CFG_OUT_LIMIT:   olim     <= cfg_wdata[14:0];
        trp_pkg::CFG_INT_LIMIT:   ilim     <= cfg_wdata[14:0];
        trp_pkg::CFG_DTERM_ALPHA: alpha    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // axis state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXIS_COUNT; i++) begin
        integ_st[i] <= '0;
        prev_st[i]  <= '0;
        filt_st[i]  <= '0;
      end
    end else begin
      unique case (cmd.op)
        trp_pkg::OP_CLEAR: begin
          for (int i = 0; i < AXIS_COUNT; i++) begin
            integ_st[i] <= '0;
            prev_st[i]  <= '0;
            filt_st[i]  <= '0;
          end
        end
        trp_pkg::OP_FUPD: begin
          filt_st[ax] <= f_new;
          prev_st[ax] <= gy_q[axg];
        end
        trp_pkg::OP_DTERM: begin
          if (!integ_q) begin
            integ_st[ax] <= '0;
          end
        end
        trp_pkg::OP_IDIV_WAIT: begin
          if (div_done) begin
            integ_st[ax] <= i_new;
          end
        end
        default: ;
      endcase
    end
  end

  // sample latch, working registers and result beat
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      trp_pkg::OP_LOAD: begin
        sp_q[0] <= in_beat.setpoint_roll;
        sp_q[1] <= in_beat.setpoint_pitch;
        sp_q[2] <= in_beat.setpoint_yaw;
        gy_q[0] <= in_beat.gyro_x;
        gy_q[1] <= in_beat.gyro_y;
        gy_q[2] <= in_beat.gyro_z;
        dt_q    <= in_beat.dt_us;
        integ_q <= in_beat.integrate;
        clear_q <= in_beat.clear;
        for (int i = 0; i < trp_pkg::AXIS_MAX; i++) begin
          cmd_w[i] <= '0;
        end
      end
      trp_pkg::OP_DMUL, trp_pkg::OP_FMUL, trp_pkg::OP_PMUL, trp_pkg::OP_IMUL_E,
      trp_pkg::OP_IMUL_T: begin
        prod <= prod_next;
      end
      trp_pkg::OP_KDMUL: begin
        p_reg <= p_shr[29:0];
        prod  <= prod_next;
      end
      trp_pkg::OP_DTERM: begin
        dterm_reg <= dt_shr[34:0];
      end
      trp_pkg::OP_DDIV_GO, trp_pkg::OP_IDIV_GO: begin
        div_neg <= prod[PW-1];
      end
      trp_pkg::OP_DDIV_WAIT: begin
        if (div_done) begin
          d_reg <= d_sat;
        end
      end
      trp_pkg::OP_SUM: begin
        cmd_w[axg] <= cmd_sat;
      end
      trp_pkg::OP_OUT: begin
        res_roll  <= cmd_w[0];
        res_pitch <= cmd_w[1];
        res_yaw   <= cmd_w[2];
      end
      default: ;
    endcase
  end

  // status to the controller
  assign status.div_done = div_done;
  assign status.clear    = clear_q;
  assign status.dt_zero  = (dt_q == '0);
  assign status.integ    = integ_q;
endmodule

>>> rtl/trp_ctrl.sv
// sequencer: steps each axis through the shared multiplier and divider
module trp_ctrl #(
  parameter int AXIS_COUNT = trp_pkg::AXIS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  trp_pkg::dp_status_t status,
  output trp_pkg::dp_cmd_t    cmd
);
  localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam logic [AW-1:0] LAST = AW'(AXIS_COUNT - 1);

  trp_pkg::state_t state, state_next;
  logic [AW-1:0]   axis;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  // state, axis counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= trp_pkg::ST_IDLE;
      axis      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == trp_pkg::ST_DISPATCH) begin
        axis <= '0;
      end else if (state == trp_pkg::ST_SUM && axis != LAST) begin
        axis <= axis + 1'b1;
      end
      if (state == trp_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      trp_pkg::ST_IDLE:      if (in_valid) state_next = trp_pkg::ST_DISPATCH;
      trp_pkg::ST_DISPATCH: begin
        if (status.clear || status.dt_zero) begin
          state_next = trp_pkg::ST_DONE;
        end else begin
          state_next = trp_pkg::ST_DMUL;
        end
      end
      trp_pkg::ST_DMUL:      state_next = trp_pkg::ST_DDIV_GO;
      trp_pkg::ST_DDIV_GO:   state_next = trp_pkg::ST_DDIV_WAIT;
      trp_pkg::ST_DDIV_WAIT: if (status.div_done) state_next = trp_pkg::ST_FMUL;
      trp_pkg::ST_FMUL:      state_next = trp_pkg::ST_FUPD;
      trp_pkg::ST_FUPD:      state_next = trp_pkg::ST_PMUL;
      trp_pkg::ST_PMUL:      state_next = trp_pkg::ST_KDMUL;
      trp_pkg::ST_KDMUL:     state_next = trp_pkg::ST_DTERM;
      trp_pkg::ST_DTERM: begin
        state_next = status.integ ? trp_pkg::ST_IMUL_E : trp_pkg::ST_SUM;
      end
      trp_pkg::ST_IMUL_E:    state_next = trp_pkg::ST_IMUL_T;
      trp_pkg::ST_IMUL_T:    state_next = trp_pkg::ST_IDIV_GO;
      trp_pkg::ST_IDIV_GO:   state_next = trp_pkg::ST_IDIV_WAIT;
      trp_pkg::ST_IDIV_WAIT: if (status.div_done) state_next = trp_pkg::ST_SUM;
      trp_pkg::ST_SUM: begin
        state_next = (axis == LAST) ? trp_pkg::ST_DONE : trp_pkg::ST_DMUL;
      end
      trp_pkg::ST_DONE:      if (out_free) state_next = trp_pkg::ST_IDLE;
      default:               state_next = trp_pkg::ST_IDLE;
    endcase
  end

  // commands to the datapath
  always_comb begin
    in_ready = (state == trp_pkg::ST_IDLE);
    cmd.axis = trp_pkg::AXIS_IW'(axis);
    cmd.op   = trp_pkg::OP_NONE;
    unique case (state)
      trp_pkg::ST_IDLE:      cmd.op = in_valid ? trp_pkg::OP_LOAD : trp_pkg::OP_NONE;
      trp_pkg::ST_DISPATCH:  cmd.op = status.clear ? trp_pkg::OP_CLEAR : trp_pkg::OP_NONE;
      trp_pkg::ST_DMUL:      cmd.op = trp_pkg::OP_DMUL;
      trp_pkg::ST_DDIV_GO:   cmd.op = trp_pkg::OP_DDIV_GO;
      trp_pkg::ST_DDIV_WAIT: cmd.op = trp_pkg::OP_DDIV_WAIT;
      trp_pkg::ST_FMUL:      cmd.op = trp_pkg::OP_FMUL;
      trp_pkg::ST_FUPD:      cmd.op = trp_pkg::OP_FUPD;
      trp_pkg::ST_PMUL:      cmd.op = trp_pkg::OP_PMUL;
      trp_pkg::ST_KDMUL:     cmd.op = trp_pkg::OP_KDMUL;
      trp_pkg::ST_DTERM:     cmd.op = trp_pkg::OP_DTERM;
      trp_pkg::ST_IMUL_E:    cmd.op = trp_pkg::OP_IMUL_E;
      trp_pkg::ST_IMUL_T:    cmd.op = trp_pkg::OP_IMUL_T;
      trp_pkg::ST_IDIV_GO:   cmd.op = trp_pkg::OP_IDIV_GO;
      trp_pkg::ST_IDIV_WAIT: cmd.op = trp_pkg::OP_IDIV_WAIT;
      trp_pkg::ST_SUM:       cmd.op = trp_pkg::OP_SUM;
      trp_pkg::ST_DONE:      cmd.op = out_free ? trp_pkg::OP_OUT : trp_pkg::OP_NONE;
      default:               cmd.op = trp_pkg::OP_NONE;
    endcase
  end
endmodule

>>> sim/tb_three_axis_rate_pid.sv
// testbench for the three-axis rate pid: random and directed samples against a predictor
`timescale 1ns / 1ps

module tb_three_axis_rate_pid;
  import trp_pkg::*;

  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } cmd_beat_t;

  // predictor of the axis commands and store of the commands still due
  class pid_scoreboard;
    logic [47:0] gains [3];
    logic [14:0] out_lim;
    logic [14:0] int_lim;
    logic [15:0] alpha;
    longint      integ_acc [3];
    longint      prev_rate [3];
    longint      filt_deriv [3];
    cmd_beat_t   cmd_due [$];
    int          fails;

    function new();
      fails = 0;
      gains[0] = GAINS_RP_RESET;
      gains[1] = GAINS_RP_RESET;
      gains[2] = GAINS_Y_RESET;
      out_lim  = OUT_LIMIT_RESET;
      int_lim  = INT_LIMIT_RESET;
      alpha    = ALPHA_RESET;
      clear_axes();
    endfunction

    function void clear_axes();
      for (int a = 0; a < 3; a++) begin
        integ_acc[a]  = 0;
        prev_rate[a]  = 0;
        filt_deriv[a] = 0;
      end
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        CFG_ROLL_GAINS:  gains[0] = data[47:0];
        CFG_PITCH_GAINS: gains[1] = data[47:0];
        CFG_YAW_GAINS:   gains[2] = data[47:0];
        CFG_OUT_LIMIT:   out_lim  = data[14:0];
        CFG_INT_LIMIT:   int_lim  = data[14:0];
        CFG_DTERM_ALPHA: alpha    = data[15:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // one axis: error, filtered derivative on measurement, integrator, sum
    function longint axis_cmd(int a, longint sp, longint meas, longint dt, bit integ);
      longint kp, ki, kd, err, d, f, prod, mag, q, p, dterm;
      kp  = gains[a][47:32];
      ki  = gains[a][31:16];
      kd  = gains[a][15:0];
      err = sp - meas;
      d   = ((meas - prev_rate[a]) * 1000000) / dt;
      d   = clip(d, -64'sd2147483648, 64'sd2147483647);
      prev_rate[a] = meas;
      f = filt_deriv[a];
      f = f + ((longint'(alpha) * (d - f)) >>> 16);
      filt_deriv[a] = clip(f, -64'sd2147483648, 64'sd2147483647);
      if (integ) begin
        prod = err * ki * dt;
        mag  = (prod < 0) ? -prod : prod;
        q    = (mag + 64000000) / 128000000;
        if (prod < 0) q = -q;
        integ_acc[a] = clip(integ_acc[a] + q, -longint'(int_lim), longint'(int_lim));
      end else begin
        integ_acc[a] = 0;
      end
      p     = (kp * err + 64) >>> 7;
      dterm = (kd * filt_deriv[a] + 16384) >>> 15;
      return clip(p + integ_acc[a] - dterm, -longint'(out_lim), longint'(out_lim));
    endfunction

    function void note_sample(in_beat_t s);
      cmd_beat_t c;
      longint dt;
      c  = '0;
      dt = s.dt_us;
      if (s.clear) begin
        clear_axes();
      end else if (dt != 0) begin
        c.roll  = 16'(axis_cmd(0, s.setpoint_roll,  s.gyro_x, dt, s.integrate));
        c.pitch = 16'(axis_cmd(1, s.setpoint_pitch, s.gyro_y, dt, s.integrate));
        c.yaw   = 16'(axis_cmd(2, s.setpoint_yaw,   s.gyro_z, dt, s.integrate));
      end
      cmd_due.push_back(c);
    endfunction

    function void check_result(cmd_beat_t got);
      cmd_beat_t e;
      if (cmd_due.size() == 0) begin
        $error("command beat with nothing due: %0d %0d %0d", got.roll, got.pitch, got.yaw);
        fails++;
        return;
      end
      e = cmd_due.pop_front();
      if (got.roll !== e.roll) begin
        $error("cmd_roll expected %0d actual %0d", e.roll, got.roll);
        fails++;
      end
      if (got.pitch !== e.pitch) begin
        $error("cmd_pitch expected %0d actual %0d", e.pitch, got.pitch);
        fails++;
      end
      if (got.yaw !== e.yaw) begin
        $error("cmd_yaw expected %0d actual %0d", e.yaw, got.yaw);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_wdata;

  trp_in_if  in_ch ();
  trp_out_if out_ch ();

  three_axis_rate_pid dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  pid_scoreboard sb = new();
  bit idle_en;
  int stall_left;
  logic signed [15:0] gyro_walk [3];

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls in bursts
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready = 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_ch.ready = 1'b0;
      stall_left = $urandom_range(1, 11) - 1;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // result checking
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.cmd_roll, out_ch.cmd_pitch, out_ch.cmd_yaw});
  end

  task automatic send_beat(in_beat_t s);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid          = 1'b1;
    in_ch.setpoint_roll  = s.setpoint_roll;
    in_ch.setpoint_pitch = s.setpoint_pitch;
    in_ch.setpoint_yaw   = s.setpoint_yaw;
    in_ch.gyro_x         = s.gyro_x;
    in_ch.gyro_y         = s.gyro_y;
    in_ch.gyro_z         = s.gyro_z;
    in_ch.dt_us          = s.dt_us;
    in_ch.integrate      = s.integrate;
    in_ch.clear          = s.clear;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_sample(s);
  endtask

  // drop valid and let every due beat arrive, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.cmd_due.size() != 0) @(posedge clk);
    repeat (220) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic in_beat_t mk(int sr, int sp, int sy, int gx, int gy, int gz,
                                  int dt, bit integ, bit clr);
    in_beat_t s;
    s.setpoint_roll  = 16'(sr);
    s.setpoint_pitch = 16'(sp);
    s.setpoint_yaw   = 16'(sy);
    s.gyro_x         = 16'(gx);
    s.gyro_y         = 16'(gy);
    s.gyro_z         = 16'(gz);
    s.dt_us          = 16'(dt);
    s.integrate      = integ;
    s.clear          = clr;
    return s;
  endfunction

  // mostly smooth gyro traces at loop-like time steps, some wild samples
  function automatic in_beat_t rand_sample();
    in_beat_t s;
    int r;
    s = in_beat_t'({$urandom, $urandom, $urandom});
    r = $urandom_range(0, 99);
    if (r < 70) begin
      for (int a = 0; a < 3; a++)
        gyro_walk[a] = gyro_walk[a] + 16'($signed($urandom_range(0, 400)) - 200);
      s.gyro_x = gyro_walk[0];
      s.gyro_y = gyro_walk[1];
      s.gyro_z = gyro_walk[2];
      s.setpoint_roll  = 16'($signed($urandom_range(0, 8000)) - 4000);
      s.setpoint_pitch = 16'($signed($urandom_range(0, 8000)) - 4000);
      s.setpoint_yaw   = 16'($signed($urandom_range(0, 8000)) - 4000);
      s.dt_us     = 16'($urandom_range(100, 5000));
      s.integrate = ($urandom_range(0, 9) != 0);
      s.clear     = ($urandom_range(0, 49) == 0);
    end else begin
      if (r < 78) s.dt_us = 16'd0;
      else if (r < 84) s.dt_us = 16'($urandom_range(1, 3));
      s.clear = ($urandom_range(0, 14) == 0);
    end
    return s;
  endfunction

  task automatic run_random(int n);
    for (int k = 0; k < n; k++) send_beat(rand_sample());
  endtask

  task automatic set_all(logic [47:0] g0, logic [47:0] g1, logic [47:0] g2,
                         logic [14:0] ol, logic [14:0] il, logic [15:0] al);
    logic [CFG_DW-1:0] junk;
    junk = {$urandom, $urandom};
    write_cfg(CFG_ROLL_GAINS, g0);
    write_cfg(CFG_PITCH_GAINS, g1);
    write_cfg(CFG_YAW_GAINS, g2);
    write_cfg(CFG_OUT_LIMIT, {junk[47:15], ol});
    write_cfg(CFG_INT_LIMIT, {junk[47:15] ^ 33'h1ffffffff, il});
    write_cfg(CFG_DTERM_ALPHA, {junk[47:16], al});
  endtask

  // main sequence
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.setpoint_roll = '0;
    in_ch.setpoint_pitch = '0;
    in_ch.setpoint_yaw = '0;
    in_ch.gyro_x = '0;
    in_ch.gyro_y = '0;
    in_ch.gyro_z = '0;
    in_ch.dt_us = '0;
    in_ch.integrate = 1'b0;
    in_ch.clear = 1'b0;
    out_ch.ready = 1'b0;
    idle_en = 1'b1;
    stall_left = 0;
    for (int a = 0; a < 3; a++) gyro_walk[a] = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, zero step, clear, saturated derivative, integrator clamp
    send_beat(mk(32767, -32768, 0, -32768, 32767, 0, 1, 1, 0));
    send_beat(mk(-32768, 32767, 32767, 32767, -32768, -32768, 1, 1, 0));
    send_beat(mk(1000, 1000, 1000, 0, 0, 0, 0, 1, 0));
    send_beat(mk(32767, 32767, 32767, -32768, -32768, -32768, 65535, 1, 0));
    send_beat(mk(32767, 32767, 32767, -32768, -32768, -32768, 65535, 1, 0));
    send_beat(mk(-32768, -32768, -32768, 32767, 32767, 32767, 65535, 1, 0));
    send_beat(mk(500, -500, 200, 100, -100, 50, 1000, 0, 0));
    send_beat(mk(500, -500, 200, 100, -100, 50, 1000, 1, 1));
    send_beat(mk(0, 0, 0, 0, 0, 0, 0, 0, 1));
    send_beat(mk(-1, -1, -1, 1, 1, 1, 2500, 1, 0));
    send_beat(mk(2048, -2048, 1024, 0, 0, 0, 2500, 1, 0));
    send_beat(mk(2048, -2048, 1024, 0, 0, 0, 2500, 1, 0));
    send_beat(mk(0, 0, 0, 32767, -32768, 32767, 1, 0, 0));
    send_beat(mk(0, 0, 0, -32768, 32767, -32768, 1, 0, 0));
    send_beat(mk(0, 0, 0, 0, 0, 0, 65535, 0, 0));

    // pressure: hold off until everything has come
    drain();
    set_all('1, '1, '1, 15'h7fff, 15'h7fff, 16'hffff);
    write_cfg(3'd6, '1);
    write_cfg(3'd7, '1);
    send_beat(mk(32767, -32768, 32767, -32768, 32767, -32768, 1, 1, 0));
    send_beat(mk(-32768, 32767, -32768, 32767, -32768, 32767, 65535, 1, 0));
    send_beat(mk(32767, 32767, 32767, -32768, -32768, -32768, 65535, 1, 0));
    run_random(100);

    drain();
    set_all('0, '0, '0, '0, '0, '0);
    run_random(60);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      set_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
              15'($urandom), 15'($urandom), 16'($urandom));
      run_random(100);
    end

    drain();
    set_all(GAINS_RP_RESET, GAINS_RP_RESET, GAINS_Y_RESET,
            OUT_LIMIT_RESET, INT_LIMIT_RESET, ALPHA_RESET);
    run_random(120);

    // last part without idling
    idle_en = 1'b0;
    run_random(120);

    drain();
    if (sb.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> three_axis_rate_pid.f
rtl/trp_pkg.sv
rtl/trp_in_if.sv
rtl/trp_out_if.sv
rtl/trp_div.sv
rtl/trp_datapath.sv
rtl/trp_ctrl.sv
rtl/three_axis_rate_pid.sv
sim/tb_three_axis_rate_pid.sv
